>>> design/bba_pkg.sv
// shared types, codes and constants of the bitmap block allocator
package bba_pkg;

	localparam int NUM_BLOCKS_DEF = 4096;

	localparam logic [12:0] CNT_MAX = 13'h1FFF;

	localparam logic [2:0] OP_ALLOC_NEXT = 3'd0;
	localparam logic [2:0] OP_ALLOC_RES  = 3'd1;
	localparam logic [2:0] OP_FREE       = 3'd2;
	localparam logic [2:0] OP_SET_USED   = 3'd3;
	localparam logic [2:0] OP_QUERY      = 3'd4;
	localparam logic [2:0] OP_LOAD       = 3'd5;
	localparam logic [2:0] OP_RELOAD     = 3'd6;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	localparam logic [2:0] CFG_BLOCKS_IN_USE    = 3'd0;
	localparam logic [2:0] CFG_ROVER_WRAP_BLOCK = 3'd1;
	localparam logic [2:0] CFG_RES_LIMIT_BLOCK  = 3'd2;
	localparam logic [2:0] CFG_INIT_TOTAL_FREE  = 3'd3;
	localparam logic [2:0] CFG_INIT_GROUP_FREE  = 3'd4;
	localparam logic [2:0] CFG_INIT_ROVER       = 3'd5;

	localparam logic [12:0] BLOCKS_IN_USE_RST = 13'd4096;

	typedef struct packed {
		logic [2:0]  op;
		logic [11:0] block;
		logic [7:0]  map_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] alloc_block;
		logic        is_free;
		logic [12:0] total_free;
		logic [12:0] group_free;
	} out_item_t;

	typedef struct packed {
		logic [12:0] blocks_in_use;
		logic [11:0] rover_wrap_block;
		logic [11:0] reserved_limit_block;
		logic [12:0] init_total_free;
		logic [12:0] init_group_free;
		logic [12:0] init_rover;
	} cfg_regs_t;

	typedef struct packed {
		logic       found;
		logic [2:0] pos;
		logic       test;
		logic [7:0] upd;
	} bu_res_t;

endpackage

>>> design/bba_ram.sv
// generic single write, single read memory with registered read data
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/bba_bitunit.sv
// shared byte unit: lowest free bit search, bit test and bit update
module bba_bitunit (
	input  logic [7:0]       data,
	input  logic [7:0]       mask,
	input  logic [2:0]       idx,
	input  logic             use_first,
	input  logic             set_val,
	output bba_pkg::bu_res_t res
);
	import bba_pkg::*;

	logic [7:0] hits;
	logic [2:0] first;
	logic [2:0] sel;

	always_comb begin
		hits  = data & mask;
		first = '0;
		for (int b = 7; b >= 0; b--) begin
			if (hits[b]) begin
				first = 3'(b);
			end
		end
		sel        = use_first ? first : idx;
		res.found  = |hits;
		res.pos    = first;
		res.test   = data[idx];
		res.upd    = data;
		res.upd[sel] = set_val;
	end

endmodule

>>> design/bba_seq.sv
// operation sequencer: counters, rover, map byte scan and read-modify-write
module bba_seq #(
	parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
	localparam int MAP_BYTES = NUM_BLOCKS / 8,
	localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bba_pkg::in_item_t   item,
	input  bba_pkg::cfg_regs_t  cfg,
	output logic                res_valid,
	input  logic                res_take,
	output bba_pkg::out_item_t  res,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output logic [7:0]          mem_wdata,
	output logic                mem_re,
	output logic [AW-1:0]       mem_raddr,
	input  logic [7:0]          mem_rdata
);
	import bba_pkg::*;

	localparam logic [12:0] CNT_CAP =
		13'((NUM_BLOCKS < int'(CNT_MAX)) ? NUM_BLOCKS : int'(CNT_MAX));

	typedef enum logic [1:0] {S_IDLE, S_RD, S_CHK, S_DONE} state_t;

	state_t      state_q;
	logic [2:0]  op_q;
	logic [11:0] blk_q;
	logic [9:0]  cur_q;
	logic [9:0]  s_byte_q;
	logic [2:0]  s_lo_q;
	logic        first_q;
	logic        wrap_q;
	logic [1:0]  status_q;
	logic [11:0] grant_q;
	logic        qfree_q;
	logic [12:0] total_q;
	logic [12:0] group_q;
	logic [12:0] rover_q;

	logic        accept;
	logic [12:0] count;
	logic [12:0] cnt_m1;
	logic [9:0]  last_byte;
	logic [12:0] start;
	logic [9:0]  res_lim;
	logic [9:0]  last_res;
	logic        load_ok;
	logic        is_alloc;
	logic        last_visit;
	logic [7:0]  lim_mask;
	logic [7:0]  lo_mask;
	logic [7:0]  hi_mask;
	logic [7:0]  scan_mask;
	logic        chk_we;
	bu_res_t     bu;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign count     = (int'(cfg.blocks_in_use) < NUM_BLOCKS) ? cfg.blocks_in_use
		: 13'(NUM_BLOCKS);
	assign cnt_m1    = count - 13'd1;
	assign last_byte = cnt_m1[12:3];
	assign start     = (rover_q < count) ? rover_q : '0;
	assign res_lim   = {1'b0, cfg.reserved_limit_block[11:3]};
	assign last_res  = (int'(res_lim) > MAP_BYTES - 1) ? 10'(MAP_BYTES - 1) : res_lim;
	assign load_ok   = int'(item.block[11:3]) < MAP_BYTES;
	assign is_alloc  = (op_q == OP_ALLOC_NEXT) || (op_q == OP_ALLOC_RES);

	// scan window: start offset on the first visit, below it on the return visit
	assign last_visit = wrap_q && (cur_q == s_byte_q);
	assign lim_mask   = (cur_q == count[12:3]) ? ~(8'hFF << count[2:0]) : 8'hFF;
	assign lo_mask    = first_q ? (8'hFF << s_lo_q) : 8'hFF;
	assign hi_mask    = last_visit ? ~(8'hFF << s_lo_q) : 8'hFF;
	assign scan_mask  = (op_q == OP_ALLOC_NEXT) ? (lim_mask & lo_mask & hi_mask) : 8'hFF;

	bba_bitunit u_bitunit (
		.data      (mem_rdata),
		.mask      (scan_mask),
		.idx       (blk_q[2:0]),
		.use_first (is_alloc),
		.set_val   (op_q == OP_FREE),
		.res       (bu)
	);

	assign chk_we = (state_q == S_CHK) && ((is_alloc && bu.found) || (op_q == OP_FREE)
		|| (op_q == OP_SET_USED));

	assign mem_re    = (state_q == S_RD);
	assign mem_raddr = AW'(cur_q);
	assign mem_we    = chk_we || (accept && (item.op == OP_LOAD) && load_ok);
	assign mem_waddr = (state_q == S_IDLE) ? AW'(item.block[11:3]) : AW'(cur_q);
	assign mem_wdata = (state_q == S_IDLE) ? item.map_byte : bu.upd;

	assign res_valid       = (state_q == S_DONE);
	assign res.status      = status_q;
	assign res.alloc_block = grant_q;
	assign res.is_free     = qfree_q;
	assign res.total_free  = total_q;
	assign res.group_free  = group_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			total_q  <= '0;
			group_q  <= '0;
			rover_q  <= '0;
			status_q <= ST_OK;
			grant_q  <= '0;
			qfree_q  <= 1'b0;
			first_q  <= 1'b0;
			wrap_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= item.op;
						blk_q    <= item.block;
						status_q <= ST_OK;
						grant_q  <= '0;
						qfree_q  <= 1'b0;
						first_q  <= 1'b1;
						wrap_q   <= 1'b0;
						unique case (item.op)
							OP_ALLOC_NEXT: begin
								if (group_q == '0 || count == '0) begin
									status_q <= ST_NOSPACE;
									state_q  <= S_DONE;
								end else begin
									cur_q    <= start[12:3];
									s_byte_q <= start[12:3];
									s_lo_q   <= start[2:0];
									state_q  <= S_RD;
								end
							end
							OP_ALLOC_RES: begin
								cur_q   <= '0;
								state_q <= S_RD;
							end
							OP_FREE, OP_SET_USED, OP_QUERY: begin
								if ({1'b0, item.block} >= count) begin
									status_q <= ST_RANGE;
									state_q  <= S_DONE;
								end else begin
									cur_q   <= {1'b0, item.block[11:3]};
									state_q <= S_RD;
								end
							end
							OP_LOAD: begin
								if (!load_ok) begin
									status_q <= ST_RANGE;
								end
								state_q <= S_DONE;
							end
							OP_RELOAD: begin
								total_q <= cfg.init_total_free;
								group_q <= cfg.init_group_free;
								rover_q <= cfg.init_rover;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					unique case (op_q)
						OP_ALLOC_NEXT: begin
							if (bu.found) begin
								grant_q <= 12'({cur_q, bu.pos});
								total_q <= (total_q == '0) ? '0 : total_q - 13'd1;
								group_q <= (group_q == '0) ? '0 : group_q - 13'd1;
								rover_q <= (rover_q < count) ? rover_q + 13'd1
									: {1'b0, cfg.rover_wrap_block};
								state_q <= S_DONE;
							end else if (last_visit) begin
								status_q <= ST_NOSPACE;
								state_q  <= S_DONE;
							end else begin
								first_q <= 1'b0;
								if (cur_q >= last_byte) begin
									cur_q  <= '0;
									wrap_q <= 1'b1;
								end else begin
									cur_q <= cur_q + 10'd1;
								end
								state_q <= S_RD;
							end
						end
						OP_ALLOC_RES: begin
							if (bu.found) begin
								grant_q <= 12'({cur_q, bu.pos});
								total_q <= (total_q == '0) ? '0 : total_q - 13'd1;
								group_q <= (group_q == '0) ? '0 : group_q - 13'd1;
								state_q <= S_DONE;
							end else if (cur_q == last_res) begin
								status_q <= ST_NOSPACE;
								state_q  <= S_DONE;
							end else begin
								cur_q   <= cur_q + 10'd1;
								state_q <= S_RD;
							end
						end
						OP_FREE: begin
							total_q <= (total_q < CNT_CAP) ? total_q + 13'd1 : CNT_CAP;
							group_q <= (group_q < CNT_CAP) ? group_q + 13'd1 : CNT_CAP;
							state_q <= S_DONE;
						end
						OP_SET_USED: begin
							total_q <= (total_q == '0) ? '0 : total_q - 13'd1;
							state_q <= S_DONE;
						end
						OP_QUERY: begin
							qfree_q <= bu.test;
							state_q <= S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("sequencer idle after a transfer in");

	a_alloc_write_found: assert property (@(posedge clk) disable iff (!arst_n)
		(chk_we && is_alloc) |-> bu.found)
		else $error("allocation write without a free bit");

	a_next_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_CHK) && (op_q == OP_ALLOC_NEXT) && bu.found)
		|-> ({cur_q, bu.pos} < count))
		else $error("next-fit grant beyond block count");

	a_group_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && !accept) |=> $stable(group_q))
		else $error("group count moved while idle");

endmodule

>>> design/bitmap_block_allocator.sv
// Bitmap block allocator: one free bit per block in a byte-wide map memory, with total and
// group free counts and a next-fit search rover. One operation is in flight at a time; the
// map has a single read port and every map access goes through a read and a check state.
// Load, reload and rejected operations go straight to the result; free, set used and query
// read and check one map byte; an allocation reads and checks each map byte scanned, up to
// blocks / 8 + 1 bytes for next-fit and the reserved bytes for the reserved search. A result
// waits in an output register, so the next operation may be taken while it is held. Map
// bytes must be loaded before they are searched or read; there is no clearing pass after
// reset. The user must write configuration only while the block is idle; it is not enforced.
module bitmap_block_allocator #(
	parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bba_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output bba_pkg::out_item_t  out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [12:0]         cfg_data
);
	import bba_pkg::*;

	localparam int MAP_BYTES = NUM_BLOCKS / 8;
	localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

	cfg_regs_t   cfg_q;
	logic        out_valid_q;
	out_item_t   out_item_q;
	logic        res_valid;
	logic        res_take;
	out_item_t   res;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]  mem_wdata;
	logic        mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]  mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blocks_in_use        <= BLOCKS_IN_USE_RST;
			cfg_q.rover_wrap_block     <= '0;
			cfg_q.reserved_limit_block <= '0;
			cfg_q.init_total_free      <= '0;
			cfg_q.init_group_free      <= '0;
			cfg_q.init_rover           <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BLOCKS_IN_USE:    cfg_q.blocks_in_use        <= cfg_data;
				CFG_ROVER_WRAP_BLOCK: cfg_q.rover_wrap_block     <= cfg_data[11:0];
				CFG_RES_LIMIT_BLOCK:  cfg_q.reserved_limit_block <= cfg_data[11:0];
				CFG_INIT_TOTAL_FREE:  cfg_q.init_total_free      <= cfg_data;
				CFG_INIT_GROUP_FREE:  cfg_q.init_group_free      <= cfg_data;
				CFG_INIT_ROVER:       cfg_q.init_rover           <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bba_seq #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.item      (in_item),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bba_ram #(
		.WIDTH (8),
		.DEPTH (MAP_BYTES)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register, refilled in the cycle the held result is transferred
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
